@@ rtl/core/mte_pkg.sv @@
// shared types, constants and byte tables for the midi track event encoder
// no dependencies
package mte_pkg;

  localparam int TICK_BITS_DEF = 28;
  localparam int TICK_W        = 28;  // width of the tick field on the port
  localparam int VLQ_BITS      = 28;  // four 7-bit groups
  localparam int IDX_W         = 5;   // byte index within one transaction's output

  // command codes
  localparam logic [1:0] CMD_NOTE = 2'd0;
  localparam logic [1:0] CMD_PRE  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [7:0] STATUS_ON  = 8'h90;
  localparam logic [7:0] STATUS_OFF = 8'h80;

  localparam logic [IDX_W-1:0] PRE_LAST = IDX_W'(26);
  localparam logic [IDX_W-1:0] END_LAST = IDX_W'(3);

  // one classified item waiting for the byte emitter
  typedef struct packed {
    logic [1:0]          cmd;
    logic [VLQ_BITS-1:0] delta;
    logic [1:0]          vlq_hi;  // number of vlq bytes minus one
    logic                note_on;
    logic [6:0]          pitch;
    logic [6:0]          velocity;
    logic                err;
  } job_t;

  function automatic logic [7:0] pre_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd1, 5'd5, 5'd13, 5'd17, 5'd21: b = 8'hB0;
      5'd2:    b = 8'h0A;
      5'd3:    b = 8'h40;
      5'd6:    b = 8'h07;
      5'd7:    b = 8'h64;
      5'd9:    b = 8'hE0;
      5'd11:   b = 8'h40;
      5'd14:   b = 8'h65;
      5'd18:   b = 8'h64;
      5'd22:   b = 8'h06;
      5'd23:   b = 8'h0C;
      5'd25:   b = 8'hC0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] end_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd1:    b = 8'hFF;
      2'd2:    b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/mte_if.sv @@
// channel interfaces for the input events and the output byte stream
// depends on mte_pkg
interface mte_in_if
  import mte_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [TICK_W-1:0] tick;
  logic              note_on;
  logic [6:0]        pitch;
  logic [6:0]        velocity;

  modport source (output valid, cmd, tick, note_on, pitch, velocity, input ready);
  modport sink   (input valid, cmd, tick, note_on, pitch, velocity, output ready);
endinterface

interface mte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last;
  logic       order_error;

  modport source (output valid, byte_out, last, order_error, input ready);
  modport sink   (input valid, byte_out, last, order_error, output ready);
endinterface

@@ rtl/core/mte_front.sv @@
// front end: accepts events, forms the tick delta and vlq length, keeps previous tick
// depends on mte_pkg
module mte_front
  import mte_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [TICK_W-1:0] in_tick,
  input  logic              in_note_on,
  input  logic [6:0]        in_pitch,
  input  logic [6:0]        in_velocity,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  logic [TICK_BITS-1:0] prev_tick_r, prev_tick_nxt;
  logic [TICK_BITS-1:0] tick_m;
  logic [TICK_BITS-1:0] delta;
  logic [VLQ_BITS-1:0]  delta_ext;
  logic                 err;
  logic                 accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign tick_m   = in_tick[TICK_BITS-1:0];
  assign err      = (in_cmd == CMD_NOTE) && (tick_m < prev_tick_r);
  assign delta    = err ? '0 : tick_m - prev_tick_r;
  assign delta_ext = VLQ_BITS'(delta);

  // unused command code is swallowed without output
  assign push = accept && (in_cmd == CMD_NOTE || in_cmd == CMD_PRE || in_cmd == CMD_END);

  always_comb begin
    push_job.cmd      = in_cmd;
    push_job.delta    = delta_ext;
    push_job.note_on  = in_note_on;
    push_job.pitch    = in_pitch;
    push_job.velocity = in_velocity;
    push_job.err      = err;
    if (delta_ext[27:21] != 7'd0) begin
      push_job.vlq_hi = 2'd3;
    end else if (delta_ext[20:14] != 7'd0) begin
      push_job.vlq_hi = 2'd2;
    end else if (delta_ext[13:7] != 7'd0) begin
      push_job.vlq_hi = 2'd1;
    end else begin
      push_job.vlq_hi = 2'd0;
    end
  end

  always_comb begin
    prev_tick_nxt = prev_tick_r;
    if (accept) begin
      if (in_cmd == CMD_NOTE && !err) begin
        prev_tick_nxt = tick_m;
      end else if (in_cmd == CMD_END) begin
        prev_tick_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tick_r <= '0;
    end else begin
      prev_tick_r <= prev_tick_nxt;
    end
  end

endmodule

@@ rtl/core/mte_queue.sv @@
// two-entry queue of classified jobs between front end and byte emitter
// depends on mte_pkg
module mte_queue
  import mte_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic q_valid,
  output job_t q_job,
  input  logic pop
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/mte_back.sv @@
// byte emitter: walks the head job into the output register one byte per cycle,
// unless out_ready stalls it; depends on mte_pkg
module mte_back
  import mte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_last,
  output logic       out_order_error
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             err_r;
  logic             advance;
  logic [7:0]       cur_byte;
  logic             cur_last;
  logic [IDX_W-1:0] vlq_hi_ext;
  logic [IDX_W-1:0] off;
  logic [1:0]       grp;
  logic [6:0]       grp_bits;

  assign advance    = q_valid && (!valid_r || out_ready);
  assign vlq_hi_ext = IDX_W'(q_job.vlq_hi);
  assign off        = idx_r - vlq_hi_ext;  // 1 status, 2 pitch, 3 velocity
  assign grp        = q_job.vlq_hi - idx_r[1:0];

  always_comb begin
    case (grp)
      2'd0:    grp_bits = q_job.delta[6:0];
      2'd1:    grp_bits = q_job.delta[13:7];
      2'd2:    grp_bits = q_job.delta[20:14];
      default: grp_bits = q_job.delta[27:21];
    endcase
  end

  always_comb begin
    cur_byte = 8'h00;
    cur_last = 1'b0;
    case (q_job.cmd)
      CMD_NOTE: begin
        if (idx_r <= vlq_hi_ext) begin
          // continuation bit on every vlq byte but the final one
          cur_byte = {(idx_r != vlq_hi_ext), grp_bits};
        end else if (off == IDX_W'(1)) begin
          cur_byte = q_job.note_on ? STATUS_ON : STATUS_OFF;
        end else if (off == IDX_W'(2)) begin
          cur_byte = {1'b0, q_job.pitch};
        end else begin
          cur_byte = {1'b0, q_job.velocity};
          cur_last = 1'b1;
        end
      end
      CMD_PRE: begin
        cur_byte = pre_byte(idx_r);
        cur_last = (idx_r == PRE_LAST);
      end
      CMD_END: begin
        cur_byte = end_byte(idx_r[1:0]);
        cur_last = (idx_r == END_LAST);
      end
      default: begin
        cur_byte = 8'h00;
        cur_last = 1'b1;
      end
    endcase
  end

  assign pop = advance && cur_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (advance) begin
      idx_nxt   = cur_last ? '0 : idx_r + IDX_W'(1);
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
      err_r  <= (q_job.cmd == CMD_NOTE) && q_job.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte_out    = byte_r;
  assign out_last        = last_r;
  assign out_order_error = err_r;

endmodule

@@ rtl/core/midi_track_event_encoder.sv @@
// midi track event encoder: note, preamble and end-of-track commands to smf track bytes
// a transaction is registered in the queue, then its first byte in the output register
// throughput: one output byte per clock unless out_ready stalls or the queue is empty;
// notes are 4 to 7 bytes (vlq length + 3), the preamble 27, end of track 4; set by the single byte
// emitter behind a 2-entry queue. reset (synchronous, active low) clears previous tick,
// the queue and the output register. depends on mte_pkg, mte_if, mte_front, mte_queue, mte_back
module midi_track_event_encoder
  import mte_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  mte_in_if.sink  in_ch,
  mte_out_if.source out_ch
);

  logic q_full;
  logic push;
  job_t push_job;
  logic q_valid;
  job_t q_job;
  logic pop;

  mte_front #(
    .TICK_BITS (TICK_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .in_tick     (in_ch.tick),
    .in_note_on  (in_ch.note_on),
    .in_pitch    (in_ch.pitch),
    .in_velocity (in_ch.velocity),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  mte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  mte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte_out    (out_ch.byte_out),
    .out_last        (out_ch.last),
    .out_order_error (out_ch.order_error)
  );

endmodule
